>>> rtl/core/dsi_gateway_ior_parser_macros.svh
// Assertion macros for the gateway IOR parser RTL.
`ifndef DSI_GATEWAY_IOR_PARSER_MACROS_SVH
`define DSI_GATEWAY_IOR_PARSER_MACROS_SVH

// Same-cycle implication, checked on clk, masked during rst.
`define DSIGW_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, masked during rst.
`define DSIGW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dsigw_pkg.sv
// Package: request/result types, status codes and constants for the IOR parser.
`default_nettype none

package dsigw_pkg;

  // Fixed framing lengths and expected version
  localparam int unsigned HEAD_BYTES      = 12;
  localparam int unsigned SERVER_ID_BYTES = 20;
  localparam logic [15:0] VERSION_OK      = 16'h0100;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W    = 2;
  localparam logic [1:0]  CFG_ADAPT_LEN  = 2'd0;
  localparam logic [1:0]  CFG_PROF_TAG   = 2'd1;
  localparam logic [1:0]  CFG_LOC_TAG    = 2'd2;
  localparam int unsigned CFG_DATA_W     = 32;

  // Configuration reset values
  localparam logic [7:0]  ADAPT_LEN_RST  = 8'd0;
  localparam logic [31:0] PROF_TAG_RST   = 32'h4953_4F06;
  localparam logic [31:0] LOC_TAG_RST    = 32'h4953_4F50;

  // Result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_PROF_MISS   = 2'd1;
  localparam logic [1:0] ST_LOC_MISS    = 2'd2;
  localparam logic [1:0] ST_KEY_LONG    = 2'd3;

  localparam logic [2:0] MAX_KEY_BYTES  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_start;
  } byte_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] carousel_num;
    logic [15:0] module_num;
    logic [31:0] object_key;
    logic [2:0]  key_length;
    logic        profile_count_warning;
    logic        lite_count_warning;
    logic        version_warning;
  } result_t;

  // Engine output towards the result register
  typedef struct packed {
    logic    valid;
    result_t data;
  } emit_t;

endpackage

`default_nettype wire

>>> rtl/core/dsigw_engine.sv
// Byte-wise parse engine: phase, field counter, shift register and saved fields.
`default_nettype none

module dsigw_engine (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire dsigw_pkg::byte_req_t step_data,
  input  wire logic [7:0]          adaptation_length,
  input  wire logic [31:0]         profile_tag,
  input  wire logic [31:0]         location_tag,
  output dsigw_pkg::emit_t         emit
);
  import dsigw_pkg::*;

  // Parse phase codes
  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_HEAD     = 5'd1;
  localparam logic [4:0] PH_PRIV1    = 5'd2;
  localparam logic [4:0] PH_PRIV2    = 5'd3;
  localparam logic [4:0] PH_TYPELEN  = 5'd4;
  localparam logic [4:0] PH_TYPEID   = 5'd5;
  localparam logic [4:0] PH_PCOUNT   = 5'd6;
  localparam logic [4:0] PH_PTAG     = 5'd7;
  localparam logic [4:0] PH_BODYSIZE = 5'd8;
  localparam logic [4:0] PH_ORDER    = 5'd9;
  localparam logic [4:0] PH_LITE     = 5'd10;
  localparam logic [4:0] PH_LTAG     = 5'd11;
  localparam logic [4:0] PH_OBJSIZE  = 5'd12;
  localparam logic [4:0] PH_CAROUSEL = 5'd13;
  localparam logic [4:0] PH_MODULE   = 5'd14;
  localparam logic [4:0] PH_VERSION  = 5'd15;
  localparam logic [4:0] PH_KEYLEN   = 5'd16;
  localparam logic [4:0] PH_KEY      = 5'd17;

  localparam logic [31:0] FIXED_SKIP = 32'(HEAD_BYTES + SERVER_ID_BYTES);

  // Warning flag bits
  localparam int unsigned WB_PROFILE = 0;
  localparam int unsigned WB_LITE    = 1;
  localparam int unsigned WB_VERSION = 2;

  logic [4:0]  phase,          phase_next;
  logic [31:0] skip_count,     skip_count_next;
  logic [31:0] field_shift,    field_shift_next;
  logic [31:0] saved_carousel, saved_carousel_next;
  logic [15:0] saved_module,   saved_module_next;
  logic [2:0]  warning_flags,  warning_flags_next;
  logic [2:0]  key_bytes_left, key_bytes_left_next;

  // Effective state once a message start has been applied
  logic [4:0]  ph;
  logic [31:0] cnt;
  logic [31:0] shv;
  logic [31:0] cnt_dec;

  // Next-state and result for the byte being stepped
  always_comb begin
    ph                  = phase;
    cnt                 = skip_count;
    field_shift_next    = field_shift;
    saved_carousel_next = saved_carousel;
    saved_module_next   = saved_module;
    warning_flags_next  = warning_flags;
    key_bytes_left_next = key_bytes_left;

    if (step_data.message_start) begin
      ph                  = PH_HEAD;
      cnt                 = FIXED_SKIP + {24'd0, adaptation_length};
      field_shift_next    = '0;
      saved_carousel_next = '0;
      saved_module_next   = '0;
      warning_flags_next  = '0;
      key_bytes_left_next = '0;
    end

    phase_next      = ph;
    skip_count_next = cnt;
    shv             = {field_shift_next[23:0], step_data.data_byte};
    cnt_dec         = cnt - 32'd1;

    emit                          = '0;
    emit.data.carousel_num        = saved_carousel_next;
    emit.data.module_num          = saved_module_next;
    emit.data.profile_count_warning = warning_flags_next[WB_PROFILE];
    emit.data.lite_count_warning    = warning_flags_next[WB_LITE];
    emit.data.version_warning       = warning_flags_next[WB_VERSION];

    if (ph != PH_IDLE && cnt != 32'd0) begin
      field_shift_next = shv;
      skip_count_next  = cnt_dec;
      if (cnt_dec == 32'd0) begin
        // Field complete: act on it and open the next one
        field_shift_next = '0;
        unique case (ph)
          PH_HEAD: begin
            phase_next = PH_PRIV1; skip_count_next = 32'd2;
          end
          PH_PRIV1: begin
            if (shv == 32'd0) begin
              phase_next = PH_PRIV2; skip_count_next = 32'd2;
            end else begin
              phase_next = PH_TYPELEN; skip_count_next = 32'd4;
            end
          end
          PH_PRIV2: begin
            phase_next = PH_TYPELEN; skip_count_next = 32'd4;
          end
          PH_TYPELEN: begin
            if (shv == 32'd0) begin
              phase_next = PH_PCOUNT; skip_count_next = 32'd4;
            end else begin
              phase_next = PH_TYPEID; skip_count_next = shv;
            end
          end
          PH_TYPEID: begin
            phase_next = PH_PCOUNT; skip_count_next = 32'd4;
          end
          PH_PCOUNT: begin
            if (shv > 32'd1) warning_flags_next[WB_PROFILE] = 1'b1;
            phase_next = PH_PTAG; skip_count_next = 32'd4;
          end
          PH_PTAG: begin
            if (shv != profile_tag) begin
              emit.valid       = 1'b1;
              emit.data.status = ST_PROF_MISS;
              phase_next       = PH_IDLE;
              skip_count_next  = '0;
            end else begin
              phase_next = PH_BODYSIZE; skip_count_next = 32'd4;
            end
          end
          PH_BODYSIZE: begin
            phase_next = PH_ORDER; skip_count_next = 32'd1;
          end
          PH_ORDER: begin
            phase_next = PH_LITE; skip_count_next = 32'd1;
          end
          PH_LITE: begin
            if (shv != 32'd2) warning_flags_next[WB_LITE] = 1'b1;
            phase_next = PH_LTAG; skip_count_next = 32'd4;
          end
          PH_LTAG: begin
            if (shv != location_tag) begin
              emit.valid       = 1'b1;
              emit.data.status = ST_LOC_MISS;
              phase_next       = PH_IDLE;
              skip_count_next  = '0;
            end else begin
              phase_next = PH_OBJSIZE; skip_count_next = 32'd1;
            end
          end
          PH_OBJSIZE: begin
            phase_next = PH_CAROUSEL; skip_count_next = 32'd4;
          end
          PH_CAROUSEL: begin
            saved_carousel_next = shv;
            phase_next = PH_MODULE; skip_count_next = 32'd2;
          end
          PH_MODULE: begin
            saved_module_next = shv[15:0];
            phase_next = PH_VERSION; skip_count_next = 32'd2;
          end
          PH_VERSION: begin
            if (shv[15:0] != VERSION_OK) warning_flags_next[WB_VERSION] = 1'b1;
            phase_next = PH_KEYLEN; skip_count_next = 32'd1;
          end
          PH_KEYLEN: begin
            if (shv > {29'd0, MAX_KEY_BYTES}) begin
              emit.valid       = 1'b1;
              emit.data.status = ST_KEY_LONG;
              phase_next       = PH_IDLE;
              skip_count_next  = '0;
            end else if (shv == 32'd0) begin
              emit.valid       = 1'b1;
              emit.data.status = ST_OK;
              phase_next       = PH_IDLE;
              skip_count_next  = '0;
            end else begin
              key_bytes_left_next = shv[2:0];
              phase_next = PH_KEY; skip_count_next = shv;
            end
          end
          PH_KEY: begin
            emit.valid           = 1'b1;
            emit.data.status     = ST_OK;
            emit.data.object_key = shv;
            emit.data.key_length = key_bytes_left_next;
            phase_next           = PH_IDLE;
            skip_count_next      = '0;
          end
          default: begin
            phase_next      = PH_IDLE;
            skip_count_next = '0;
          end
        endcase
      end
    end
  end

  // Parser state, advanced once per stepped byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      skip_count     <= '0;
      field_shift    <= '0;
      saved_carousel <= '0;
      saved_module   <= '0;
      warning_flags  <= '0;
      key_bytes_left <= '0;
    end else if (step) begin
      phase          <= phase_next;
      skip_count     <= skip_count_next;
      field_shift    <= field_shift_next;
      saved_carousel <= saved_carousel_next;
      saved_module   <= saved_module_next;
      warning_flags  <= warning_flags_next;
      key_bytes_left <= key_bytes_left_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dsi_gateway_ior_parser.sv
// Top level of the download-server-initiate gateway IOR parser.
// Throughput: one byte request per cycle while no result is held, with no gaps between messages.
// Stalls: a result held by result_ready blocks the parse step and so the byte input.
// Result path: the closing byte is accepted into the byte input register, then the
// parse step writes the result register.
// Reset (rst, synchronous): parser idle, both registers empty, configuration to defaults.
`default_nettype none
`include "dsi_gateway_ior_parser_macros.svh"

module dsi_gateway_ior_parser (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               byte_valid,
  output logic                                    byte_ready,
  input  wire dsigw_pkg::byte_req_t                byte_data,
  output logic                                    result_valid,
  input  wire logic                               result_ready,
  output dsigw_pkg::result_t                      result_data,
  input  wire logic                               cfg_write_en,
  input  wire logic [dsigw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [dsigw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dsigw_pkg::*;

  logic [7:0]  adaptation_length;
  logic [31:0] profile_tag;
  logic [31:0] location_tag;

  logic      s1_valid;
  byte_req_t s1_data;
  logic      advance;
  emit_t     emit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      adaptation_length <= ADAPT_LEN_RST;
      profile_tag       <= PROF_TAG_RST;
      location_tag      <= LOC_TAG_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_ADAPT_LEN: adaptation_length <= cfg_wdata[7:0];
        CFG_PROF_TAG:  profile_tag       <= cfg_wdata;
        CFG_LOC_TAG:   location_tag      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Byte input register; steps into the engine whenever the result slot is free
  assign advance    = s1_valid && (!result_valid || result_ready);
  assign byte_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ready) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      s1_data <= byte_data;
    end
  end

  dsigw_engine u_engine (
    .clk               (clk),
    .rst               (rst),
    .step              (advance),
    .step_data         (s1_data),
    .adaptation_length (adaptation_length),
    .profile_tag       (profile_tag),
    .location_tag      (location_tag),
    .emit              (emit)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= emit.valid;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit.valid) begin
      result_data <= emit.data;
    end
  end

  // Checks
  `DSIGW_ASSERT_NOW(a_key_only_ok, result_valid && result_data.status != ST_OK,
    result_data.key_length == 3'd0 && result_data.object_key == 32'd0,
    "key reported with a failing status")
  `DSIGW_ASSERT_NOW(a_tag_miss_no_ids,
    result_valid && (result_data.status == ST_PROF_MISS ||
                     result_data.status == ST_LOC_MISS),
    result_data.carousel_num == 32'd0 && result_data.module_num == 16'd0,
    "carousel or module id reported before it was parsed")
  `DSIGW_ASSERT_NOW(a_key_len_range, result_valid,
    result_data.key_length <= MAX_KEY_BYTES, "key length above limit")
  `DSIGW_ASSERT_NEXT(a_stage_hold, s1_valid && !advance,
    s1_valid && $stable(s1_data), "input stage lost a stalled byte")

endmodule

`default_nettype wire

>>> bench/dsi_gateway_ior_parser_test.sv
// Self-checking bench for the gateway IOR parser: byte requests in, result requests checked.
`timescale 1ns / 100ps

module dsi_gateway_ior_parser_test;
  import dsigw_pkg::*;

  localparam int HOLD_CYCLES = 500;

  // Parse states of the bench's own model of the parser
  typedef enum logic [4:0] {
    PS_IDLE, PS_HEAD, PS_PRIV1, PS_PRIV2, PS_TYPE_LEN, PS_TYPE_ID, PS_PROF_COUNT,
    PS_PROF_TAG, PS_BODY_LEN, PS_BYTE_ORDER, PS_LITE_COUNT, PS_LOC_TAG, PS_OBJ_LEN,
    PS_CAROUSEL, PS_MODULE, PS_VERSION, PS_KEY_LEN, PS_KEY
  } parse_state_e;

  // Field values of one generated message
  typedef struct {
    logic [15:0] priv1;
    logic [15:0] priv2;
    logic [31:0] type_len;
    logic [31:0] prof_count;
    logic [31:0] prof_tag;
    logic [31:0] body_len;
    logic [7:0]  order_flag;
    logic [7:0]  lite_count;
    logic [31:0] loc_tag;
    logic [7:0]  obj_len;
    logic [31:0] carousel;
    logic [15:0] module_num;
    logic [15:0] version;
    logic [7:0]  key_len;
    logic [31:0] key_val;
    int          tail_len;
    int          cut_at;
  } dsi_plan_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  byte_req_t  byte_data = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  result_t    result_data;
  logic       cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_ADAPT_LEN;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  dsi_gateway_ior_parser dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Stimulus and checking state
  byte_req_t tx_bytes[$];
  byte_req_t msg_buf[$];
  result_t   gateway_results_due[$];
  int        bytes_queued = 0;
  int        results_checked = 0;
  int        fail_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        mix_idle = 1'b0;
  logic      byte_taken = 1'b0;
  int        hold_requests = 0;
  int        hold_seen = 0;
  int        hold_left = 0;

  // Model copy of the configuration
  logic [7:0]  cfg_adapt = ADAPT_LEN_RST;
  logic [31:0] cfg_prof_tag = PROF_TAG_RST;
  logic [31:0] cfg_loc_tag = LOC_TAG_RST;

  // Model copy of the parser state
  parse_state_e pstate = PS_IDLE;
  logic [31:0]  bytes_left = '0;
  logic [31:0]  gathered = '0;
  logic [31:0]  carousel_seen = '0;
  logic [15:0]  module_seen = '0;
  logic         warn_prof = 1'b0;
  logic         warn_lite = 1'b0;
  logic         warn_ver = 1'b0;
  logic [2:0]   key_total = '0;

  function automatic void enter_state(parse_state_e s, logic [31:0] n);
    pstate = s;
    bytes_left = n;
    gathered = '0;
  endfunction

  function automatic void post_result(logic [1:0] st, logic [31:0] key, logic [2:0] klen);
    result_t r;
    r.status = st;
    r.carousel_num = carousel_seen;
    r.module_num = module_seen;
    r.object_key = key;
    r.key_length = klen;
    r.profile_count_warning = warn_prof;
    r.lite_count_warning = warn_lite;
    r.version_warning = warn_ver;
    gateway_results_due.push_back(r);
    enter_state(PS_IDLE, '0);
  endfunction

  // Advance the parser model by one accepted byte request
  function automatic void parse_byte(byte_req_t req);
    logic [31:0] v;
    if (req.message_start) begin
      carousel_seen = '0;
      module_seen = '0;
      warn_prof = 1'b0;
      warn_lite = 1'b0;
      warn_ver = 1'b0;
      key_total = '0;
      enter_state(PS_HEAD, HEAD_BYTES + SERVER_ID_BYTES + cfg_adapt);
    end
    if (pstate == PS_IDLE || bytes_left == 0) return;
    gathered = {gathered[23:0], req.data_byte};
    bytes_left = bytes_left - 1;
    if (bytes_left != 0) return;
    v = gathered;
    case (pstate)
      PS_HEAD: enter_state(PS_PRIV1, 2);
      PS_PRIV1: begin
        if (v == 0) enter_state(PS_PRIV2, 2);
        else enter_state(PS_TYPE_LEN, 4);
      end
      PS_PRIV2: enter_state(PS_TYPE_LEN, 4);
      PS_TYPE_LEN: begin
        if (v == 0) enter_state(PS_PROF_COUNT, 4);
        else enter_state(PS_TYPE_ID, v);
      end
      PS_TYPE_ID: enter_state(PS_PROF_COUNT, 4);
      PS_PROF_COUNT: begin
        if (v > 1) warn_prof = 1'b1;
        enter_state(PS_PROF_TAG, 4);
      end
      PS_PROF_TAG: begin
        if (v != cfg_prof_tag) post_result(ST_PROF_MISS, '0, '0);
        else enter_state(PS_BODY_LEN, 4);
      end
      PS_BODY_LEN: enter_state(PS_BYTE_ORDER, 1);
      PS_BYTE_ORDER: enter_state(PS_LITE_COUNT, 1);
      PS_LITE_COUNT: begin
        if (v != 2) warn_lite = 1'b1;
        enter_state(PS_LOC_TAG, 4);
      end
      PS_LOC_TAG: begin
        if (v != cfg_loc_tag) post_result(ST_LOC_MISS, '0, '0);
        else enter_state(PS_OBJ_LEN, 1);
      end
      PS_OBJ_LEN: enter_state(PS_CAROUSEL, 4);
      PS_CAROUSEL: begin
        carousel_seen = v;
        enter_state(PS_MODULE, 2);
      end
      PS_MODULE: begin
        module_seen = v[15:0];
        enter_state(PS_VERSION, 2);
      end
      PS_VERSION: begin
        if (v[15:0] != VERSION_OK) warn_ver = 1'b1;
        enter_state(PS_KEY_LEN, 1);
      end
      PS_KEY_LEN: begin
        if (v > MAX_KEY_BYTES) post_result(ST_KEY_LONG, '0, '0);
        else if (v == 0) post_result(ST_OK, '0, '0);
        else begin
          key_total = v[2:0];
          enter_state(PS_KEY, v);
        end
      end
      default: post_result(ST_OK, v, key_total);
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    if (gateway_results_due.size() == 0) begin
      $error("result request with none expected: 0x%0h", got);
      fail_count++;
      return;
    end
    want = gateway_results_due.pop_front();
    results_checked++;
    check_field("status", want.status, got.status);
    check_field("carousel_num", want.carousel_num, got.carousel_num);
    check_field("module_num", want.module_num, got.module_num);
    check_field("object_key", want.object_key, got.object_key);
    check_field("key_length", want.key_length, got.key_length);
    check_field("profile_count_warning", want.profile_count_warning,
                got.profile_count_warning);
    check_field("lite_count_warning", want.lite_count_warning, got.lite_count_warning);
    check_field("version_warning", want.version_warning, got.version_warning);
  endfunction

  // Monitor: both handshakes sampled on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= byte_valid && byte_ready;
      if (byte_valid && byte_ready) parse_byte(byte_data);
      if (result_valid && result_ready) check_result(result_data);
    end
  end

  // Driver: next byte request presented on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || byte_taken) begin
      if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        byte_valid <= 1'b1;
        byte_data <= tx_bytes.pop_front();
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Message building
  function automatic void add_field(logic [31:0] v, int n);
    byte_req_t b;
    for (int i = n - 1; i >= 0; i--) begin
      b.data_byte = v[8*i +: 8];
      b.message_start = 1'b0;
      msg_buf.push_back(b);
    end
  endfunction

  function automatic void flush_buf(int keep);
    for (int i = 0; i < keep && i < msg_buf.size(); i++) tx_bytes.push_back(msg_buf[i]);
    bytes_queued += (keep < msg_buf.size()) ? keep : msg_buf.size();
    msg_buf.delete();
  endfunction

  function automatic dsi_plan_t good_plan();
    dsi_plan_t p;
    p.priv1 = 16'($urandom_range(65535, 1));
    p.priv2 = 16'($urandom);
    p.type_len = 2;
    p.prof_count = 1;
    p.prof_tag = cfg_prof_tag;
    p.body_len = $urandom;
    p.order_flag = 8'($urandom);
    p.lite_count = 2;
    p.loc_tag = cfg_loc_tag;
    p.obj_len = 8'($urandom);
    p.carousel = $urandom;
    p.module_num = 16'($urandom);
    p.version = VERSION_OK;
    p.key_len = 4;
    p.key_val = $urandom;
    p.tail_len = 0;
    p.cut_at = 0;
    return p;
  endfunction

  // Mostly well-formed, with each checked field sometimes off its usual value
  function automatic dsi_plan_t random_plan();
    dsi_plan_t p;
    p = good_plan();
    if ($urandom_range(3) == 0) p.priv1 = '0;
    case ($urandom_range(29))
      0: p.type_len = $urandom;
      1, 2, 3, 4, 5: p.type_len = '0;
      default: p.type_len = $urandom_range(8, 1);
    endcase
    case ($urandom_range(9))
      7: p.prof_count = '0;
      8: p.prof_count = 2;
      9: p.prof_count = $urandom;
      default: ;
    endcase
    case ($urandom_range(19))
      0: p.prof_tag = $urandom;
      1: p.prof_tag = cfg_prof_tag ^ (32'd1 << $urandom_range(31));
      default: ;
    endcase
    if ($urandom_range(3) == 0) p.lite_count = 8'($urandom);
    case ($urandom_range(19))
      0: p.loc_tag = $urandom;
      1: p.loc_tag = cfg_loc_tag ^ (32'd1 << $urandom_range(31));
      default: ;
    endcase
    case ($urandom_range(7))
      6: p.version = 16'($urandom);
      7: p.version = VERSION_OK ^ (16'd1 << $urandom_range(15));
      default: ;
    endcase
    case ($urandom_range(19))
      16, 17: p.key_len = 5;
      18: p.key_len = 8'($urandom_range(255, 6));
      19: p.key_len = 8'hFF;
      default: p.key_len = 8'($urandom_range(4));
    endcase
    if ($urandom_range(3) == 0) p.tail_len = $urandom_range(6, 1);
    if ($urandom_range(11) == 0) p.cut_at = $urandom_range(60, 1);
    return p;
  endfunction

  function automatic void queue_message(dsi_plan_t p);
    int keep;
    for (int i = 0; i < HEAD_BYTES + SERVER_ID_BYTES + cfg_adapt; i++) add_field($urandom, 1);
    msg_buf[0].message_start = 1'b1;
    add_field(p.priv1, 2);
    if (p.priv1 == 0) add_field(p.priv2, 2);
    add_field(p.type_len, 4);
    // an oversized type id just runs on into whatever follows
    for (int i = 0; i < p.type_len && i < 24; i++) add_field($urandom, 1);
    add_field(p.prof_count, 4);
    add_field(p.prof_tag, 4);
    add_field(p.body_len, 4);
    add_field(p.order_flag, 1);
    add_field(p.lite_count, 1);
    add_field(p.loc_tag, 4);
    add_field(p.obj_len, 1);
    add_field(p.carousel, 4);
    add_field(p.module_num, 2);
    add_field(p.version, 2);
    add_field(p.key_len, 1);
    if (p.key_len <= MAX_KEY_BYTES) add_field(p.key_val, int'(p.key_len));
    else add_field($urandom, 4);
    for (int i = 0; i < p.tail_len; i++) add_field($urandom, 1);
    keep = (p.cut_at != 0) ? p.cut_at : msg_buf.size();
    flush_buf(keep);
  endfunction

  // Loose bytes, now and then carrying a spurious message start
  function automatic void queue_noise();
    int n;
    n = $urandom_range(10, 1);
    for (int i = 0; i < n; i++) begin
      add_field($urandom, 1);
      msg_buf[i].message_start = ($urandom_range(7) == 0);
    end
    flush_buf(n);
  endfunction

  function automatic void set_idle(int mode);
    case (mode)
      1: begin
        send_idle_pct = 64;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 64;
      end
      3: begin
        send_idle_pct = 27;
        recv_stall_pct = 27;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endfunction

  // Wait until every request is through and every result is in, then let the pipe empty
  task automatic settle();
    while (tx_bytes.size() != 0 || byte_valid || gateway_results_due.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_config(logic [7:0] adapt, logic [31:0] ptag, logic [31:0] ltag);
    cfg_adapt = adapt;
    cfg_prof_tag = ptag;
    cfg_loc_tag = ltag;
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= CFG_ADAPT_LEN;
    cfg_wdata <= {24'd0, adapt};
    @(negedge clk);
    cfg_index <= CFG_PROF_TAG;
    cfg_wdata <= ptag;
    @(negedge clk);
    cfg_index <= CFG_LOC_TAG;
    cfg_wdata <= ltag;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic run_traffic(int byte_goal, int result_goal);
    int first;
    first = bytes_queued;
    while (bytes_queued - first < byte_goal || results_checked < result_goal) begin
      if (mix_idle) set_idle($urandom_range(3));
      if ($urandom_range(6) == 0) queue_noise();
      else queue_message(random_plan());
      while (tx_bytes.size() > 200) @(negedge clk);
    end
    settle();
  endtask

  // Test sequence
  initial begin
    dsi_plan_t p;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed messages on the reset configuration
    set_idle(0);
    add_field($urandom, 3);
    flush_buf(3);
    p = good_plan();
    p.key_val = '1;
    p.carousel = '1;
    p.module_num = '1;
    queue_message(p);
    // second private length, empty type id, empty key, trailing bytes ignored
    p = good_plan();
    p.priv1 = '0;
    p.priv2 = '1;
    p.type_len = '0;
    p.key_len = '0;
    p.carousel = '0;
    p.module_num = '0;
    p.tail_len = 4;
    queue_message(p);
    p = good_plan();
    p.key_len = 5;
    p.prof_count = '1;
    p.lite_count = '1;
    p.version = '1;
    queue_message(p);
    p = good_plan();
    p.key_len = 8'hFF;
    p.prof_count = 2;
    p.lite_count = '0;
    p.version = '0;
    queue_message(p);
    p = good_plan();
    p.prof_tag = ~cfg_prof_tag;
    queue_message(p);
    p = good_plan();
    p.loc_tag = cfg_loc_tag ^ 32'd1;
    p.prof_count = '0;
    queue_message(p);
    // restart part way through the profile body
    p = good_plan();
    p.cut_at = 50;
    queue_message(p);
    p = good_plan();
    p.key_len = 1;
    p.key_val = '0;
    queue_message(p);
    p = good_plan();
    p.key_len = 2;
    p.version = VERSION_OK + 16'd1;
    queue_message(p);
    p = good_plan();
    p.key_len = 3;
    p.type_len = 8;
    queue_message(p);
    settle();

    // Random traffic over several settings, extremes first
    set_idle(1);
    set_config(8'd0, 32'h0000_0000, 32'hFFFF_FFFF);
    run_traffic(150, 0);
    set_idle(2);
    set_config(8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
    run_traffic(250, 0);
    set_idle(3);
    set_config(8'($urandom_range(6)), $urandom, $urandom);
    run_traffic(150, 0);

    // Long result hold-off with the sender flat out; settle waits for every result
    set_idle(0);
    set_config(8'd1, PROF_TAG_RST, LOC_TAG_RST);
    hold_requests++;
    run_traffic(200, 0);

    mix_idle = 1'b1;
    set_config(8'($urandom_range(3)), $urandom, $urandom);
    run_traffic(150, 48);

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("dsi_gateway_ior_parser_test: PASS");
    end else begin
      $display("dsi_gateway_ior_parser_test: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("dsi_gateway_ior_parser_test: FAIL");
    $finish;
  end

endmodule
